/* rtl/risc_subset_core_step_defines.svh */
// assertion macros shared by the risc subset core step
// depends on clk and arst_n being visible where a macro is used
`ifndef RISC_SUBSET_CORE_STEP_DEFINES_SVH
`define RISC_SUBSET_CORE_STEP_DEFINES_SVH

// same-cycle implication, off during reset
`define RSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("core step check failed");

// next-cycle implication, off during reset
`define RSS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("core step check failed");

`endif

/* rtl/rss_pkg.sv */
// shared constants, opcodes and write request types of the risc subset core step
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

	// data memory geometry
	localparam int DATA_BYTES = 1024;
	localparam int MEM_WORDS  = DATA_BYTES / 4;
	localparam int MIDX_W     = $clog2(MEM_WORDS);

	// register file geometry
	localparam int REG_W     = 5;
	localparam int RF_DEPTH  = 32;
	localparam logic [REG_W-1:0] SP_REG = 5'd29;
	localparam logic [REG_W-1:0] RA_REG = 5'd31;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SP = 1'b1;

	// item operations
	localparam logic OP_EXEC    = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	// primary opcodes
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_JAL   = 6'h03;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_SLTI  = 6'h0A;
	localparam logic [5:0] OPC_ANDI  = 6'h0C;
	localparam logic [5:0] OPC_ORI   = 6'h0D;
	localparam logic [5:0] OPC_NORI  = 6'h0E;
	localparam logic [5:0] OPC_LUI   = 6'h0F;
	localparam logic [5:0] OPC_LB    = 6'h20;
	localparam logic [5:0] OPC_LH    = 6'h21;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_LBU   = 6'h24;
	localparam logic [5:0] OPC_LHU   = 6'h25;
	localparam logic [5:0] OPC_SB    = 6'h28;
	localparam logic [5:0] OPC_SH    = 6'h29;
	localparam logic [5:0] OPC_SW    = 6'h2B;
	localparam logic [5:0] OPC_HALT  = 6'h3F;

	// function codes of the register form
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_NAND = 6'h28;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	// register file write request
	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] idx;
		logic [31:0]      data;
	} rf_wr_t;

	// data memory write request, lane 3 is the lowest byte address
	typedef struct packed {
		logic              en;
		logic [MIDX_W-1:0] idx;
		logic [3:0]        mask;
		logic [31:0]       data;
	} dm_wr_t;

endpackage

`default_nettype wire

/* rtl/rss_regfile.sv */
// register file: 32 words, two synchronous read ports, one write port
// depends on rss_pkg; unwritten entries read zero, r29 reads the stack default
`timescale 1ns / 1ps
`default_nettype none

module rss_regfile (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     re,
	input  logic [rss_pkg::REG_W-1:0] raddr_a,
	input  logic [rss_pkg::REG_W-1:0] raddr_b,
	input  logic [31:0]              sp_default,
	input  rss_pkg::rf_wr_t          wr,
	output logic [31:0]              rdata_a,
	output logic [31:0]              rdata_b
);
	import rss_pkg::*;

	logic [31:0]         mem [RF_DEPTH];
	logic [RF_DEPTH-1:0] valid_q;
	logic [31:0]         rd_a_q, rd_b_q;
	logic                byp_a_q, byp_b_q;
	logic [31:0]         byp_val_q;

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// registered reads with write-through capture
	always_ff @(posedge clk) begin
		if (re) begin
			if (valid_q[raddr_a]) begin
				rd_a_q <= mem[raddr_a];
			end else begin
				rd_a_q <= (raddr_a == SP_REG) ? sp_default : 32'd0;
			end
			if (valid_q[raddr_b]) begin
				rd_b_q <= mem[raddr_b];
			end else begin
				rd_b_q <= (raddr_b == SP_REG) ? sp_default : 32'd0;
			end
			byp_a_q   <= wr.en && (wr.idx == raddr_a);
			byp_b_q   <= wr.en && (wr.idx == raddr_b);
			byp_val_q <= wr.data;
		end
	end

	assign rdata_a = byp_a_q ? byp_val_q : rd_a_q;
	assign rdata_b = byp_b_q ? byp_val_q : rd_b_q;

endmodule

`default_nettype wire

/* rtl/rss_dmem.sv */
// data memory: big-endian words with byte lanes, one read and one write port
// depends on rss_pkg; unwritten words read zero
`timescale 1ns / 1ps
`default_nettype none

module rss_dmem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       re,
	input  logic [rss_pkg::MIDX_W-1:0] raddr,
	input  rss_pkg::dm_wr_t            wr,
	output logic [31:0]                rdata
);
	import rss_pkg::*;

	logic [31:0]          mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic [31:0]          rd_q;
	logic [3:0]           byp_mask_q;
	logic [31:0]          byp_data_q;

	// word valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	// lane writes, untouched lanes of a fresh word are zeroed
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < 4; i++) begin
				if (wr.mask[i]) begin
					mem[wr.idx][8*i +: 8] <= wr.data[8*i +: 8];
				end else if (!valid_q[wr.idx]) begin
					mem[wr.idx][8*i +: 8] <= 8'd0;
				end
			end
		end
	end

	// registered read with same-edge write capture
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q       <= valid_q[raddr] ? mem[raddr] : 32'd0;
			byp_mask_q <= (wr.en && (wr.idx == raddr)) ? wr.mask : 4'd0;
			byp_data_q <= wr.data;
		end
	end

	// merge captured lanes
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rdata[8*i +: 8] = byp_mask_q[i] ? byp_data_q[8*i +: 8] : rd_q[8*i +: 8];
		end
	end

endmodule

`default_nettype wire

/* rtl/risc_subset_core_step.sv */
// top level of the risc subset core step: decode, execute and result staging
// depends on rss_pkg, rss_regfile, rss_dmem and the assertion macro header
//
// channel   direction  handshake              payload
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in         in_valid/in_ready      op, instruction, preload_index, preload_data
// out       out        out_valid/out_ready    next_pc ... halted
//
// a new word is not taken while the previous one is still in the input stage:
// it passes the register read, then the execute stage with the data memory read,
// then the memory and register writeback, and then reaches the output register
// reset clears control state and valid bits at once, no clearing pass
// a held output word stalls writeback, then execute, then input
`timescale 1ns / 1ps
`default_nettype none
`include "risc_subset_core_step_defines.svh"

module risc_subset_core_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [31:0]                   instruction,
	input  logic [7:0]                    preload_index,
	input  logic [31:0]                   preload_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   next_pc,
	output logic                          reg_written,
	output logic [4:0]                    reg_index,
	output logic [31:0]                   reg_value,
	output logic                          write_zero_error,
	output logic                          number_overflow,
	output logic                          address_overflow,
	output logic                          misaligned,
	output logic                          halted
);
	import rss_pkg::*;

	// configuration and architectural state
	logic [31:0] start_pc_q, start_sp_q, pc_q, sp_q;
	logic        started_q, stopped_q;

	// stage registers
	logic        s1_v, s2_v;
	logic        op_s1;
	logic [31:0] ins_s1, pdata_s1;
	logic [7:0]  pidx_s1;

	logic        accept, s1_adv, s2_adv;

	// s2 payload
	logic [31:0]      npc_s2, rval_s2;
	logic             rw_s2, ld_s2, zero_s2, ovf_s2, aovf_s2, mis_s2, halt_s2;
	logic [REG_W-1:0] ridx_s2;
	logic [5:0]       opc_s2;
	logic [1:0]       off_s2;
	dm_wr_t           dw_s2;

	// memory interfaces
	rf_wr_t      rf_wr;
	logic [31:0] rd_a, rd_b, dm_rdata, sp_default, wb_val;

	// execute stage signals
	logic [5:0]       opc, fn;
	logic [REG_W-1:0] rs, rt, rd, sh;
	logic [31:0]      a, b, zimm, imm, cur_pc, pc4;
	logic [31:0]      add_ab, sub_ab, sum_ai, br_sum, jtarget;
	logic             ovf_add, ovf_sub, ovf_ai, ovf_br;
	logic             exec, ld, st, hop, aovf, mis, memerr, halt;
	logic             wt, zero, ovf;
	logic [REG_W-1:0] widx;
	logic [31:0]      wval, npc;
	logic [2:0]       size;
	logic [1:0]       size_m1;
	logic [3:0]       st_mask;
	logic [31:0]      st_data;
	logic             pre_ok;
	dm_wr_t           dw_s1;

	assign cfg_ready = 1'b1;
	assign in_ready  = !s1_v;
	assign accept    = in_valid && in_ready;
	assign s2_adv    = s2_v && (!out_valid || out_ready);
	assign s1_adv    = s1_v && (!s2_v || s2_adv);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= 32'd0;
			start_sp_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_PC: start_pc_q <= cfg_data;
				CFG_START_SP: start_sp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sp_default = started_q ? sp_q : start_sp_q;

	// register file, read as the word is taken
	assign rf_wr.en   = s2_adv && rw_s2;
	assign rf_wr.idx  = ridx_s2;
	assign rf_wr.data = wb_val;

	rss_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.re         (accept),
		.raddr_a    (instruction[25:21]),
		.raddr_b    (instruction[20:16]),
		.sp_default (sp_default),
		.wr         (rf_wr),
		.rdata_a    (rd_a),
		.rdata_b    (rd_b)
	);

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			ins_s1   <= instruction;
			pidx_s1  <= preload_index;
			pdata_s1 <= preload_data;
		end
	end

	// decode fields
	assign opc  = ins_s1[31:26];
	assign rs   = ins_s1[25:21];
	assign rt   = ins_s1[20:16];
	assign rd   = ins_s1[15:11];
	assign sh   = ins_s1[10:6];
	assign fn   = ins_s1[5:0];
	assign zimm = {16'd0, ins_s1[15:0]};
	assign imm  = {{16{ins_s1[15]}}, ins_s1[15:0]};

	// operands, forwarded from a writeback still held in s2
	assign a = (s2_v && rw_s2 && (ridx_s2 == rs)) ? wb_val : rd_a;
	assign b = (s2_v && rw_s2 && (ridx_s2 == rt)) ? wb_val : rd_b;

	assign exec   = !stopped_q && (op_s1 == OP_EXEC);
	assign cur_pc = started_q ? pc_q : start_pc_q;
	assign pc4    = cur_pc + 32'd4;

	// adders with signed overflow
	assign add_ab  = a + b;
	assign ovf_add = (~(a ^ b) & (a ^ add_ab)) >> 31 != 32'd0;
	assign sub_ab  = a - b;
	assign ovf_sub = ((a ^ b) & (a ^ sub_ab)) >> 31 != 32'd0;
	assign sum_ai  = a + imm;
	assign ovf_ai  = (~(a ^ imm) & (a ^ sum_ai)) >> 31 != 32'd0;
	assign br_sum  = pc4 + {imm[29:0], 2'b00};
	assign ovf_br  = (~(pc4 ^ {imm[29:0], 2'b00}) & (pc4 ^ br_sum)) >> 31 != 32'd0;
	assign jtarget = {pc4[31:28], ins_s1[25:0], 2'b00};

	// access size and checks
	always_comb begin
		if (opc[1:0] == 2'b11) begin
			size    = 3'd4;
			size_m1 = 2'd3;
		end else if (opc[0]) begin
			size    = 3'd2;
			size_m1 = 2'd1;
		end else begin
			size    = 3'd1;
			size_m1 = 2'd0;
		end
	end

	assign aovf = sum_ai > (32'(DATA_BYTES) - {29'd0, size});
	assign mis  = (sum_ai[1:0] & size_m1) != 2'd0;

	// instruction execute
	always_comb begin
		wt   = 1'b0;
		widx = rd;
		wval = 32'd0;
		zero = 1'b0;
		ovf  = 1'b0;
		npc  = pc4;
		ld   = 1'b0;
		st   = 1'b0;
		hop  = 1'b0;
		if (opc == OPC_RTYPE) begin
			case (fn)
				FN_ADD: begin
					wt = 1'b1; wval = add_ab; ovf = ovf_add;
				end
				FN_SUB: begin
					wt = 1'b1; wval = sub_ab; ovf = ovf_sub;
				end
				FN_AND:  begin wt = 1'b1; wval = a & b; end
				FN_OR:   begin wt = 1'b1; wval = a | b; end
				FN_XOR:  begin wt = 1'b1; wval = a ^ b; end
				FN_NOR:  begin wt = 1'b1; wval = ~(a | b); end
				FN_NAND: begin wt = 1'b1; wval = ~(a & b); end
				FN_SLT:  begin wt = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
				FN_SLL: begin
					wt   = !(rd == 5'd0 && rt == 5'd0 && sh == 5'd0);
					wval = b << sh;
				end
				FN_SRL: begin wt = 1'b1; wval = b >> sh; end
				FN_SRA: begin wt = 1'b1; wval = 32'($signed(b) >>> sh); end
				FN_JR:  npc = a;
				default: ;
			endcase
		end else if (opc inside {OPC_LW, OPC_LH, OPC_LHU, OPC_LB, OPC_LBU}) begin
			ld   = 1'b1;
			zero = (rt == 5'd0);
			ovf  = ovf_ai;
		end else if (opc inside {OPC_SW, OPC_SH, OPC_SB}) begin
			st  = 1'b1;
			ovf = ovf_ai;
		end else begin
			widx = rt;
			case (opc)
				OPC_ADDI: begin wt = 1'b1; wval = sum_ai; ovf = ovf_ai; end
				OPC_LUI:  begin wt = 1'b1; wval = {ins_s1[15:0], 16'd0}; end
				OPC_ANDI: begin wt = 1'b1; wval = a & zimm; end
				OPC_ORI:  begin wt = 1'b1; wval = a | zimm; end
				OPC_NORI: begin wt = 1'b1; wval = ~(a | zimm); end
				OPC_SLTI: begin wt = 1'b1; wval = {31'd0, $signed(a) < $signed(imm)}; end
				OPC_BEQ: begin
					if (a == b) begin npc = br_sum; ovf = ovf_br; end
				end
				OPC_BNE: begin
					if (a != b) begin npc = br_sum; ovf = ovf_br; end
				end
				OPC_J: npc = jtarget;
				OPC_JAL: begin
					wt = 1'b1; widx = RA_REG; wval = pc4; npc = jtarget;
				end
				OPC_HALT: hop = 1'b1;
				default: ;
			endcase
		end
		if (wt && widx == 5'd0) begin
			zero = 1'b1;
		end
	end

	assign memerr = (ld || st) && (aovf || mis);
	assign halt   = stopped_q || (exec && (hop || memerr));

	// store lanes, big-endian
	always_comb begin
		case (size_m1)
			2'd3: begin
				st_mask = 4'b1111;
				st_data = b;
			end
			2'd1: begin
				st_mask = sum_ai[1] ? 4'b0011 : 4'b1100;
				st_data = {b[15:0], b[15:0]};
			end
			default: begin
				st_mask = 4'b1000 >> sum_ai[1:0];
				st_data = {4{b[7:0]}};
			end
		endcase
	end

	assign pre_ok = 32'(pidx_s1) < 32'(MEM_WORDS);

	// memory write of this word, store or preload
	always_comb begin
		if (op_s1 == OP_PRELOAD) begin
			dw_s1.en   = !stopped_q && pre_ok;
			dw_s1.idx  = MIDX_W'(32'(pidx_s1));
			dw_s1.mask = 4'b1111;
			dw_s1.data = pdata_s1;
		end else begin
			dw_s1.en   = exec && st && !halt;
			dw_s1.idx  = sum_ai[MIDX_W+1:2];
			dw_s1.mask = st_mask;
			dw_s1.data = st_data;
		end
	end

	rss_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (s1_adv),
		.raddr  (sum_ai[MIDX_W+1:2]),
		.wr     (dw_s2 & {s2_adv, {($bits(dm_wr_t)-1){1'b1}}}),
		.rdata  (dm_rdata)
	);

	// architectural state, updated as a word leaves execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 32'd0;
			sp_q      <= 32'd0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (s1_adv && exec) begin
			started_q <= 1'b1;
			if (!started_q) begin
				sp_q <= start_sp_q;
			end
			if (halt) begin
				stopped_q <= 1'b1;
				if (!started_q) begin
					pc_q <= start_pc_q;
				end
			end else begin
				pc_q <= npc;
			end
		end
	end

	// writeback stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_adv) begin
			s2_v <= 1'b1;
		end else if (s2_adv) begin
			s2_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			npc_s2  <= (exec && !halt) ? npc : cur_pc;
			ld_s2   <= exec && !halt && ld && (rt != 5'd0);
			rw_s2   <= exec && !halt && ((wt && widx != 5'd0 && !ld) || (ld && rt != 5'd0));
			ridx_s2 <= ld ? rt : widx;
			rval_s2 <= wval;
			zero_s2 <= exec && zero;
			ovf_s2  <= exec && ovf;
			aovf_s2 <= exec && (ld || st) && aovf;
			mis_s2  <= exec && (ld || st) && mis;
			halt_s2 <= halt;
			opc_s2  <= opc;
			off_s2  <= sum_ai[1:0];
			dw_s2   <= dw_s1;
		end
	end

	// load extraction and writeback value
	always_comb begin
		logic [15:0] hw;
		logic [7:0]  by;
		hw = off_s2[1] ? dm_rdata[15:0] : dm_rdata[31:16];
		case (off_s2)
			2'd0:    by = dm_rdata[31:24];
			2'd1:    by = dm_rdata[23:16];
			2'd2:    by = dm_rdata[15:8];
			default: by = dm_rdata[7:0];
		endcase
		if (!ld_s2) begin
			wb_val = rval_s2;
		end else begin
			case (opc_s2)
				OPC_LW:  wb_val = dm_rdata;
				OPC_LH:  wb_val = {{16{hw[15]}}, hw};
				OPC_LHU: wb_val = {16'd0, hw};
				OPC_LB:  wb_val = {{24{by[7]}}, by};
				default: wb_val = {24'd0, by};
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			next_pc          <= npc_s2;
			reg_written      <= rw_s2;
			reg_index        <= rw_s2 ? ridx_s2 : 5'd0;
			reg_value        <= rw_s2 ? wb_val : 32'd0;
			write_zero_error <= zero_s2;
			number_overflow  <= ovf_s2;
			address_overflow <= aovf_s2;
			misaligned       <= mis_s2;
			halted           <= halt_s2;
		end
	end

	// checks
	`RSS_ASSERT_NXT(a_stop_sticky, stopped_q, stopped_q)
	`RSS_ASSERT_IMP(a_no_r0_write, rf_wr.en, rf_wr.idx != 5'd0)
	`RSS_ASSERT_IMP(a_one_in_exec, accept, !s1_v)
	`RSS_ASSERT_NXT(a_wb_to_out, s2_adv, out_valid)

endmodule

`default_nettype wire
